// ----- rtl/cma_pkg.sv -----
`timescale 1ns / 1ps
// cma_pkg: shared types and constants for the centered moving average block.
// No dependencies; used by centered_moving_average_masked.sv.
package cma_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int HW_BITS     = 5;

    localparam logic [HW_BITS-1:0] HW_RESET = 5'd1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          sample_ok;
        logic                          last_in;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] average;
        logic                          average_ok;
        logic                          last_out;
    } result_t;

endpackage

// ----- rtl/cma_div.sv -----
`timescale 1ns / 1ps
// cma_div: restoring divider, one quotient bit per cycle, signed dividend
// by unsigned divisor, quotient truncated toward zero. Standalone module.
module cma_div #(
    parameter int SUM_W = 38,
    parameter int CNT_W = 6
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic        [CNT_W-1:0] divisor,
    output logic                    done,
    output logic signed [SUM_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              neg_reg, neg_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  div_reg, div_next;

    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              fits;

    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign fits  = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            neg_next  = dividend[SUM_W-1];
            quo_next  = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_next  = {quo_reg[SUM_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

// ----- rtl/centered_moving_average_masked.sv -----
`timescale 1ns / 1ps
// centered_moving_average_masked: top level, window ring memory and sequencer.
// Depends on cma_pkg and cma_div.
//
//  channel   signals                              request moves
//  -------   ----------------------------------   ------------------------
//  cfg       cfg_valid / cfg_ready / cfg_data     half_window write
//  item      item_valid / item_stall / item       one sample request
//  result    result_valid / result_stall / result one averaged result
//
// A sample is registered from the item port, then written into the ring in S_UPDATE;
// each result then goes through the bit-serial divider (SUM_W = SAMPLE_BITS + 6 = 38
// at defaults), which is skipped when the centre sample is invalid or the count is zero.
// During a flush each trimmed slot adds a ring read (S_TRIM, then S_TRIM_RD).
// Reset clears the control state and sets half_window to 1; no clearing pass.
// A stalled result sits in the output register; the next sample is taken meanwhile.
module centered_moving_average_masked #(
    parameter int MAX_HALF = 31
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cma_pkg::HW_BITS-1:0]     cfg_data,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  cma_pkg::item_t                  item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output cma_pkg::result_t                result
);

    localparam int SB    = cma_pkg::SAMPLE_BITS;
    localparam int RING  = 2 * MAX_HALF + 1;
    localparam int PTR_W = $clog2(RING);
    localparam int CNT_W = $clog2(RING + 1);
    localparam int SUM_W = SB + CNT_W;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UPDATE  = 3'd1;
    localparam logic [2:0] S_PLAN    = 3'd2;
    localparam logic [2:0] S_TRIM    = 3'd3;
    localparam logic [2:0] S_TRIM_RD = 3'd4;
    localparam logic [2:0] S_DIV     = 3'd5;
    localparam logic [2:0] S_OUT     = 3'd6;

    function automatic logic [PTR_W-1:0] sub_mod(input logic [PTR_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] wa;
        logic [CNT_W:0] wb;
        logic [CNT_W:0] r;
        wa = (CNT_W + 1)'(a);
        wb = (CNT_W + 1)'(b);
        if (wa >= wb)
            r = wa - wb;
        else
            r = wa + (CNT_W + 1)'(RING) - wb;
        return PTR_W'(r);
    endfunction

    logic [2:0]                  state_reg, state_next;
    logic [cma_pkg::HW_BITS-1:0] hw_reg, hw_next;
    logic [RING-1:0]             valid_reg, valid_next;
    logic signed [SUM_W-1:0]     sum_reg, sum_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [CNT_W-1:0]            arrivals_reg, arrivals_next;
    logic [PTR_W-1:0]            ptr_reg, ptr_next;
    logic [PTR_W-1:0]            newest_reg, newest_next;
    logic [CNT_W-1:0]            e_reg, e_next;
    logic [CNT_W-1:0]            wn_reg, wn_next;
    cma_pkg::item_t              item_reg, item_next;
    logic signed [SB-1:0]        pend_avg_reg, pend_avg_next;
    logic                        pend_ok_reg, pend_ok_next;
    cma_pkg::result_t            result_reg, result_next;
    logic                        result_valid_reg, result_valid_next;

    logic [SB-1:0]               ring_mem [RING];
    logic [SB-1:0]               rd_data_reg;
    logic [PTR_W-1:0]            mem_raddr;
    logic                        mem_we;

    logic [CNT_W-1:0]            h;
    logic [CNT_W-1:0]            len;
    logic [CNT_W-1:0]            e_plus;
    logic [CNT_W-1:0]            need;
    logic [CNT_W-1:0]            cnt_m1;
    logic [PTR_W-1:0]            drop_slot;
    logic [PTR_W-1:0]            trim_slot;
    logic [PTR_W-1:0]            centre_slot;
    logic [PTR_W-1:0]            ptr_inc;
    logic                        full;
    logic                        drop_en;
    logic                        final_res;
    logic                        clear;
    logic signed [SUM_W-1:0]     rd_ext;
    logic signed [SUM_W-1:0]     smp_ext;

    logic                        div_start;
    logic                        div_done;
    logic signed [SUM_W-1:0]     div_quotient;

    always_comb
    begin
        if (int'(hw_reg) > MAX_HALF)
            h = CNT_W'(MAX_HALF);
        else
            h = CNT_W'(hw_reg);
    end

    assign len         = CNT_W'({h, 1'b1});
    assign e_plus      = e_reg + h + 1'b1;
    assign need        = (e_plus < arrivals_reg) ? e_plus : arrivals_reg;
    assign cnt_m1      = arrivals_reg - 1'b1;
    assign drop_slot   = sub_mod(ptr_reg, len);
    assign trim_slot   = sub_mod(newest_reg, wn_reg - 1'b1);
    assign centre_slot = sub_mod(newest_reg, e_reg);
    assign ptr_inc     = (ptr_reg == PTR_W'(RING - 1)) ? '0 : ptr_reg + 1'b1;
    assign full        = arrivals_reg >= len;
    assign drop_en     = full && valid_reg[drop_slot];
    assign final_res   = !item_reg.last_in || (e_reg == '0);
    assign rd_ext      = {{CNT_W{rd_data_reg[SB-1]}}, rd_data_reg};
    assign smp_ext     = {{CNT_W{item_reg.sample[SB-1]}}, item_reg.sample};
    assign mem_raddr   = (state_reg == S_TRIM) ? trim_slot : drop_slot;

    assign cfg_ready    = (state_reg == S_IDLE);
    assign item_stall   = (state_reg != S_IDLE) || cfg_valid;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next        = state_reg;
        hw_next           = hw_reg;
        valid_next        = valid_reg;
        sum_next          = sum_reg;
        count_next        = count_reg;
        arrivals_next     = arrivals_reg;
        ptr_next          = ptr_reg;
        newest_next       = newest_reg;
        e_next            = e_reg;
        wn_next           = wn_reg;
        item_next         = item_reg;
        pend_avg_next     = pend_avg_reg;
        pend_ok_next      = pend_ok_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        mem_we            = 1'b0;
        div_start         = 1'b0;
        clear             = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    hw_next = cfg_data;
                    clear   = 1'b1;
                end
                else if (item_valid)
                begin
                    item_next  = item;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                mem_we = 1'b1;
                if (drop_en)
                    valid_next[drop_slot] = 1'b0;
                valid_next[ptr_reg] = item_reg.sample_ok;
                sum_next   = sum_reg - (drop_en ? rd_ext : '0)
                           + (item_reg.sample_ok ? smp_ext : '0);
                count_next = count_reg - CNT_W'(drop_en) + CNT_W'(item_reg.sample_ok);
                if (!full)
                    arrivals_next = arrivals_reg + 1'b1;
                newest_next = ptr_reg;
                ptr_next    = ptr_inc;
                state_next  = S_PLAN;
            end
            S_PLAN:
            begin
                wn_next = arrivals_reg;
                if (item_reg.last_in)
                begin
                    e_next     = (cnt_m1 < h) ? cnt_m1 : h;
                    state_next = S_TRIM;
                end
                else if (arrivals_reg > h)
                begin
                    e_next     = h;
                    state_next = S_TRIM;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_TRIM:
            begin
                if (wn_reg > need)
                begin
                    state_next = S_TRIM_RD;
                end
                else if (valid_reg[centre_slot] && (count_reg != '0))
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    pend_avg_next = '0;
                    pend_ok_next  = 1'b0;
                    state_next    = S_OUT;
                end
            end
            S_TRIM_RD:
            begin
                if (valid_reg[trim_slot])
                begin
                    valid_next[trim_slot] = 1'b0;
                    sum_next   = sum_reg - rd_ext;
                    count_next = count_reg - 1'b1;
                end
                wn_next    = wn_reg - 1'b1;
                state_next = S_TRIM;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    pend_avg_next = div_quotient[SB-1:0];
                    pend_ok_next  = 1'b1;
                    state_next    = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.average    = pend_avg_reg;
                    result_next.average_ok = pend_ok_reg;
                    result_next.last_out   = item_reg.last_in && (e_reg == '0);
                    result_valid_next      = 1'b1;
                    if (final_res)
                    begin
                        clear      = item_reg.last_in;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        e_next     = e_reg - 1'b1;
                        state_next = S_TRIM;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (clear)
        begin
            valid_next    = '0;
            sum_next      = '0;
            count_next    = '0;
            arrivals_next = '0;
            ptr_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            hw_reg           <= cma_pkg::HW_RESET;
            valid_reg        <= '0;
            sum_reg          <= '0;
            count_reg        <= '0;
            arrivals_reg     <= '0;
            ptr_reg          <= '0;
            newest_reg       <= '0;
            e_reg            <= '0;
            wn_reg           <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            hw_reg           <= hw_next;
            valid_reg        <= valid_next;
            sum_reg          <= sum_next;
            count_reg        <= count_next;
            arrivals_reg     <= arrivals_next;
            ptr_reg          <= ptr_next;
            newest_reg       <= newest_next;
            e_reg            <= e_next;
            wn_reg           <= wn_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        pend_avg_reg <= pend_avg_next;
        pend_ok_reg  <= pend_ok_next;
        result_reg   <= result_next;
    end

    // ring of sample values, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[ptr_reg] <= item_reg.sample;
        rd_data_reg <= ring_mem[mem_raddr];
    end

    cma_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("usable count out of step with valid bits");

    a_arrivals_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        arrivals_reg <= len)
        else $error("arrival count beyond window length");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide state");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result raised outside output state");

endmodule
